[src/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies a delayed consequent
`define ASSERT_LATER2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("assertion failed");

`endif

[src/peca_pkg.sv]
// shared types and constants of the pin event channel allocator
`default_nettype none

package peca_pkg;

  localparam int unsigned Pins       = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] ReqInstall   = 2'd0;
  localparam logic [1:0] ReqUninstall = 2'd1;
  localparam logic [1:0] ReqSample    = 2'd2;

  typedef enum logic [1:0] {
    KindInstall,
    KindUninstall,
    KindSample,
    KindUnknown
  } req_kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  pin;
    logic [1:0]  edge_mode;
    logic        has_handler;
    logic [31:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] channel;
    logic [7:0] fired_mask;
    logic       irq_enabled;
  } result_t;

  // classified request held in the queue
  typedef struct packed {
    req_kind_e   kind;
    logic [4:0]  pin;
    logic [1:0]  polarity;
    logic        has_handler;
    logic        pin_ok;
    logic [31:0] pin_levels;
  } entry_t;

  typedef struct packed {
    logic irq_on;
    logic any_used;
  } status_t;

endpackage

`default_nettype wire

[src/peca_front.sv]
// front end: takes transactions and classifies them for the queue
`default_nettype none

module peca_front (
  input  wire                logic start,
  input  wire  peca_pkg::in_item_t item_i,
  input  wire                logic full_i,
  output logic                     busy,
  output logic                     push_o,
  output peca_pkg::entry_t         entry_o
);

  peca_pkg::req_kind_e kind;

  always_comb begin
    unique case (item_i.req_type)
      peca_pkg::ReqInstall:   kind = peca_pkg::KindInstall;
      peca_pkg::ReqUninstall: kind = peca_pkg::KindUninstall;
      peca_pkg::ReqSample:    kind = peca_pkg::KindSample;
      default:                kind = peca_pkg::KindUnknown;
    endcase
  end

  assign busy   = full_i;
  assign push_o = start && !full_i;

  always_comb begin
    entry_o.kind        = kind;
    entry_o.pin         = item_i.pin;
    // edge mode three wraps to polarity zero and never fires
    entry_o.polarity    = 2'(item_i.edge_mode + 2'd1);
    entry_o.has_handler = item_i.has_handler;
    entry_o.pin_ok      = {1'b0, item_i.pin} < 6'(peca_pkg::Pins);
    entry_o.pin_levels  = item_i.pin_levels;
  end

endmodule

`default_nettype wire

[src/peca_fifo.sv]
// short queue between the front end and the back end
`default_nettype none

module peca_fifo (
  input  wire                  logic clk_i,
  input  wire                  logic rst_ni,
  input  wire                  logic push_i,
  input  wire  peca_pkg::entry_t     entry_i,
  input  wire                  logic pop_i,
  output logic                       full_o,
  output logic                       valid_o,
  output peca_pkg::entry_t           head_o
);

  localparam int unsigned PtrW = $clog2(peca_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(peca_pkg::QueueDepth + 1);

  peca_pkg::entry_t mem_q [peca_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign full_o  = count_q == CntW'(peca_pkg::QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(peca_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(peca_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[src/peca_back.sv]
// back end: channel table, edge detection and result register
`default_nettype none

module peca_back #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire                  logic clk_i,
  input  wire                  logic rst_ni,
  input  wire                  logic head_valid_i,
  input  wire  peca_pkg::entry_t     head_i,
  output logic                       res_valid_o,
  output peca_pkg::result_t          res_o,
  output peca_pkg::status_t          status_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] used_q;
  logic [4:0]          pin_q [CHANNELS];
  logic [1:0]          pol_q [CHANNELS];
  logic [31:0]         prev_q;
  logic                irq_q;
  logic                res_valid_q;
  peca_pkg::result_t   res_q;

  logic [CHANNELS-1:0] match;
  logic [CHANNELS-1:0] fired;
  logic [CHANNELS-1:0] match_sel;
  logic [IdxW-1:0]     match_idx;
  logic [IdxW-1:0]     free_idx;
  logic                install_ok;
  logic                uninstall_ok;
  logic                is_sample;
  logic                any_left;
  logic                irq_next;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      logic was;
      logic now;
      was      = prev_q[pin_q[i]];
      now      = head_i.pin_levels[pin_q[i]];
      match[i] = used_q[i] && (pin_q[i] == head_i.pin);
      fired[i] = used_q[i] && ((!was && now && pol_q[i][0]) ||
                               (was && !now && pol_q[i][1]));
    end
  end

  // lowest bound channel and lowest free channel
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IdxW'(i);
      end
      if (!used_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign match_sel    = CHANNELS'(1) << match_idx;
  assign install_ok   = head_valid_i && (head_i.kind == peca_pkg::KindInstall) &&
                        head_i.pin_ok && !(|match) && !(&used_q) && head_i.has_handler;
  assign uninstall_ok = head_valid_i && (head_i.kind == peca_pkg::KindUninstall) && (|match);
  assign is_sample    = head_valid_i && (head_i.kind == peca_pkg::KindSample);
  assign any_left     = |(used_q & ~match_sel);

  always_comb begin
    priority if (install_ok) begin
      irq_next = 1'b1;
    end else if (uninstall_ok) begin
      irq_next = any_left;
    end else begin
      irq_next = irq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pin_q[i] <= '0;
        pol_q[i] <= '0;
      end
      prev_q      <= '0;
      irq_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= head_valid_i;
      irq_q       <= irq_next;
      if (install_ok) begin
        used_q[free_idx] <= 1'b1;
        pin_q[free_idx]  <= head_i.pin;
        pol_q[free_idx]  <= head_i.polarity;
      end
      if (uninstall_ok) begin
        used_q[match_idx] <= 1'b0;
        pin_q[match_idx]  <= '0;
        pol_q[match_idx]  <= '0;
      end
      if (is_sample) begin
        prev_q <= head_i.pin_levels;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_valid_i) begin
      res_q.ok          <= install_ok || uninstall_ok || is_sample;
      res_q.channel     <= install_ok   ? 3'(free_idx)  :
                           uninstall_ok ? 3'(match_idx) : 3'd0;
      res_q.fired_mask  <= is_sample ? 8'(fired) : 8'd0;
      res_q.irq_enabled <= irq_next;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_o             = res_q;
  assign status_o.irq_on   = irq_q;
  assign status_o.any_used = |used_q;

endmodule

`default_nettype wire

[src/pin_event_channel_allocator.sv]
// top level of the pin event channel allocator
// A request is taken on any clock edge where start is high and busy is low, so one request
// per cycle can be issued back to back. In the cycle after the accepting edge the back end
// reads the request from the head of the two-entry queue, looks up and updates the channel
// table and loads the result register at the next edge. result_o is therefore shown, from
// the result register, with result_valid_o high for exactly one cycle. The back end drains
// one request every cycle, so the queue never holds more than one request and busy stays
// low. There is no result backpressure: the receiver must capture each result on its strobe.
`default_nettype none
`include "assert_macros.svh"

module pin_event_channel_allocator #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire                    logic clk_i,
  input  wire                    logic rst_ni,
  input  wire                    logic start,
  output logic                         busy,
  input  wire  peca_pkg::in_item_t     item_i,
  output logic                         result_valid_o,
  output peca_pkg::result_t            result_o
);

  logic              push;
  logic              full;
  logic              head_valid;
  peca_pkg::entry_t  entry;
  peca_pkg::entry_t  head;
  peca_pkg::status_t status;

  peca_front u_front (
    .start   (start),
    .item_i  (item_i),
    .full_i  (full),
    .busy    (busy),
    .push_o  (push),
    .entry_o (entry)
  );

  peca_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (head_valid),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head)
  );

  peca_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .res_valid_o  (result_valid_o),
    .res_o        (result_o),
    .status_o     (status)
  );

  // every accepted transaction comes back with a result strobe
  `ASSERT_LATER2(a_fixed_latency, clk_i, rst_ni, start && !busy, result_valid_o)
  // interrupt flag tracks table occupancy
  `ASSERT_SAME(a_irq_tracks_table, clk_i, rst_ni, 1'b1, status.irq_on == status.any_used)
  `ASSERT_SAME(a_result_irq, clk_i, rst_ni, result_valid_o,
               result_o.irq_enabled == status.any_used)
  // a failed transaction reports channel zero
  `ASSERT_SAME(a_fail_chan_zero, clk_i, rst_ni, result_valid_o && !result_o.ok,
               result_o.channel == 3'd0)

endmodule

`default_nettype wire
